// ===== hw/rtl/sfcd_pkg.sv =====
package sfcd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [19:0] humidity_raw;
    logic [19:0] temperature_raw;
    logic [7:0]  status_byte;
    logic [1:0]  result_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] crc_initial;
    logic [7:0] crc_polynomial;
    logic [7:0] busy_mask;
  } cfg_t;

  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_INITIAL    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLYNOMIAL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUSY_MASK      = 2'd2;

  localparam logic [7:0] CRC_INITIAL_RESET    = 8'hFF;
  localparam logic [7:0] CRC_POLYNOMIAL_RESET = 8'h31;
  localparam logic [7:0] BUSY_MASK_RESET      = 8'h80;

  // bytes covered by the CRC; the byte at this position is the CRC itself
  localparam logic [2:0] CRC_BYTES = 3'd6;

  localparam logic [1:0] CODE_OK    = 2'd0;
  localparam logic [1:0] CODE_BUSY  = 2'd1;
  localparam logic [1:0] CODE_CRC   = 2'd2;
  localparam logic [1:0] CODE_SHORT = 2'd3;

  // MSB-first CRC-8, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sensor_frame_crc_decoder_top.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_item   (data_byte, frame_end)
// out      output     out_valid / out_stall out_item  (humidity, temperature, status, code)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item accepted per cycle while in_stall is low; two register stages (input register, then
// frame decode and CRC update into the result register).
// A result is loaded into the result register when the byte that ends a frame leaves the input register.
// rst is synchronous: clears valids and byte position, and sets config and decode registers to defaults.
// in_stall rises only while both the input and result registers hold items and
// out_stall is high.
module sensor_frame_crc_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sfcd_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sfcd_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import sfcd_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      res_valid;
  out_item_t res_item;
  logic      adv;
  logic      step;
  logic      core_done;
  out_item_t core_res;

  assign adv       = !(res_valid && out_stall);
  assign in_stall  = s1_valid && !adv;
  assign step      = s1_valid && adv;
  assign out_valid = res_valid;
  assign out_item  = res_item;

  sfcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfcd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .item (s1_item),
    .done (core_done),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= step && core_done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_done) begin
      res_item <= core_res;
    end
  end

endmodule

// ===== hw/rtl/sfcd_cfg.sv =====
module sfcd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output sfcd_pkg::cfg_t                cfg
);
  import sfcd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_initial    <= CRC_INITIAL_RESET;
      cfg.crc_polynomial <= CRC_POLYNOMIAL_RESET;
      cfg.busy_mask      <= BUSY_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CRC_INITIAL:    cfg.crc_initial    <= cfg_data;
        CFG_CRC_POLYNOMIAL: cfg.crc_polynomial <= cfg_data;
        CFG_BUSY_MASK:      cfg.busy_mask      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sfcd_core.sv =====
module sfcd_core (
  input  logic                clk,
  input  logic                rst,
  input  sfcd_pkg::cfg_t      cfg,
  input  logic                step,
  input  sfcd_pkg::in_item_t  item,
  output logic                done,
  output sfcd_pkg::out_item_t res
);
  import sfcd_pkg::*;

  logic [2:0]  byte_position;
  logic [7:0]  running_crc;
  logic [7:0]  held_status;
  logic [19:0] humidity_accum;
  logic [19:0] temperature_accum;

  logic [7:0]  crc_base;
  logic [7:0]  running_crc_next;
  logic [7:0]  held_status_next;
  logic [19:0] humidity_accum_next;
  logic [19:0] temperature_accum_next;
  logic        covered;
  logic [7:0]  b;

  assign b        = item.data_byte;
  assign covered  = byte_position < CRC_BYTES;
  assign done     = !covered || item.frame_end;
  assign crc_base = (byte_position == 3'd0) ? cfg.crc_initial : running_crc;
  assign running_crc_next = crc8_byte(crc_base, b, cfg.crc_polynomial);
  assign held_status_next = (byte_position == 3'd0) ? b : held_status;

  always_comb begin
    humidity_accum_next    = humidity_accum;
    temperature_accum_next = temperature_accum;
    unique case (byte_position)
      3'd0: begin
        humidity_accum_next    = '0;
        temperature_accum_next = '0;
      end
      3'd1: humidity_accum_next = {b, 12'd0};
      3'd2: humidity_accum_next = humidity_accum | {8'd0, b, 4'd0};
      3'd3: begin
        humidity_accum_next    = humidity_accum | {16'd0, b[7:4]};
        temperature_accum_next = {b[3:0], 16'd0};
      end
      3'd4: temperature_accum_next = temperature_accum | {4'd0, b, 8'd0};
      3'd5: temperature_accum_next = temperature_accum | {12'd0, b};
      default: ;
    endcase
  end

  always_comb begin
    res.humidity_raw    = '0;
    res.temperature_raw = '0;
    res.status_byte     = held_status_next;
    priority if (covered) begin
      res.result_code = CODE_SHORT;
    end else if ((held_status & cfg.busy_mask) != 8'd0) begin
      res.result_code = CODE_BUSY;
    end else if (running_crc != b) begin
      res.result_code = CODE_CRC;
    end else begin
      res.result_code     = CODE_OK;
      res.humidity_raw    = humidity_accum;
      res.temperature_raw = temperature_accum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
    end else if (step) begin
      byte_position <= done ? 3'd0 : byte_position + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc       <= CRC_INITIAL_RESET;
      held_status       <= '0;
      humidity_accum    <= '0;
      temperature_accum <= '0;
    end else if (step && covered) begin
      running_crc       <= running_crc_next;
      held_status       <= held_status_next;
      humidity_accum    <= humidity_accum_next;
      temperature_accum <= temperature_accum_next;
    end
  end

endmodule

// ===== hw/rtl/sfcd_chk.sv =====
module sfcd_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input sfcd_pkg::out_item_t             out_item
);
  import sfcd_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed under stall");

  // raw values only on a good frame
  a_zero_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_code != CODE_OK |->
      out_item.humidity_raw == 20'd0 && out_item.temperature_raw == 20'd0)
    else $error("raw values on a failed frame");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("valid or stall after reset");

endmodule

bind sensor_frame_crc_decoder_top sfcd_chk u_sfcd_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== test/tb_sensor_frame_crc_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_sensor_frame_crc_decoder_top;
  import sfcd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_BYTES = 88;

  typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_CRC_GOOD, ROW_CRC_BAD} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;
    logic       last;
    out_item_t  want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  // frame decoder shadow
  cfg_t        cfg_shadow;
  logic [2:0]  fr_pos;
  logic [7:0]  fr_crc;
  logic [7:0]  fr_status;
  logic [19:0] fr_hum;
  logic [19:0] fr_temp;

  out_item_t   pending_readings[$];
  int unsigned bytes_sent;
  int unsigned settings_used;
  int unsigned code_seen[4] = '{default: 0};
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          tx_free;
  bit          rx_free;
  bit          rx_hold_req;

  dir_row_t dir_rows [25] = '{
    '{ROW_TYPED,    8'hFF, 1'b1, '{20'd0, 20'd0, 8'hFF, CODE_SHORT}},
    '{ROW_PRED,     8'h00, 1'b0, '0},
    '{ROW_PRED,     8'hFF, 1'b0, '0},
    '{ROW_TYPED,    8'hA5, 1'b1, '{20'd0, 20'd0, 8'h00, CODE_SHORT}},
    // busy status, seventh byte without frame_end
    '{ROW_PRED,     8'h80, 1'b0, '0},
    '{ROW_PRED,     8'h12, 1'b0, '0},
    '{ROW_PRED,     8'h34, 1'b0, '0},
    '{ROW_PRED,     8'h56, 1'b0, '0},
    '{ROW_PRED,     8'h78, 1'b0, '0},
    '{ROW_PRED,     8'h9A, 1'b0, '0},
    '{ROW_TYPED,    8'h00, 1'b0, '{20'd0, 20'd0, 8'h80, CODE_BUSY}},
    // good frame, full-scale readings
    '{ROW_PRED,     8'h1C, 1'b0, '0},
    '{ROW_PRED,     8'hFF, 1'b0, '0},
    '{ROW_PRED,     8'hFF, 1'b0, '0},
    '{ROW_PRED,     8'hFF, 1'b0, '0},
    '{ROW_PRED,     8'hFF, 1'b0, '0},
    '{ROW_PRED,     8'hFF, 1'b0, '0},
    '{ROW_CRC_GOOD, 8'h00, 1'b1, '0},
    // all-zero frame, bad CRC
    '{ROW_PRED,     8'h00, 1'b0, '0},
    '{ROW_PRED,     8'h00, 1'b0, '0},
    '{ROW_PRED,     8'h00, 1'b0, '0},
    '{ROW_PRED,     8'h00, 1'b0, '0},
    '{ROW_PRED,     8'h00, 1'b0, '0},
    '{ROW_PRED,     8'h00, 1'b0, '0},
    '{ROW_CRC_BAD,  8'h00, 1'b1, '{20'd0, 20'd0, 8'h00, CODE_CRC}}
  };

  sensor_frame_crc_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] r;
    r = c ^ b;
    repeat (8) r = (r << 1) ^ (r[7] ? poly : 8'h00);
    return r;
  endfunction

  task automatic clear_frame();
    fr_pos    = '0;
    fr_crc    = cfg_shadow.crc_initial;
    fr_status = '0;
    fr_hum    = '0;
    fr_temp   = '0;
  endtask

  task automatic decode_byte(input in_item_t it, output bit has, output out_item_t res);
    has = 1'b0;
    res = '0;
    if (fr_pos < CRC_BYTES) begin
      if (fr_pos == 3'd0) begin
        fr_crc    = cfg_shadow.crc_initial;
        fr_status = it.data_byte;
        fr_hum    = '0;
        fr_temp   = '0;
      end
      fr_crc = crc8_step(fr_crc, it.data_byte, cfg_shadow.crc_polynomial);
      case (fr_pos)
        3'd1: fr_hum = {it.data_byte, 12'h000};
        3'd2: fr_hum[11:4] = it.data_byte;
        3'd3: begin
          fr_hum[3:0] = it.data_byte[7:4];
          fr_temp     = {it.data_byte[3:0], 16'h0000};
        end
        3'd4: fr_temp[15:8] = it.data_byte;
        3'd5: fr_temp[7:0] = it.data_byte;
        default: ;
      endcase
      if (!it.frame_end) begin
        fr_pos = fr_pos + 3'd1;
        return;
      end
      res.status_byte = fr_status;
      res.result_code = CODE_SHORT;
    end else begin
      res.status_byte = fr_status;
      if ((fr_status & cfg_shadow.busy_mask) != 8'h00) begin
        res.result_code = CODE_BUSY;
      end else if (fr_crc != it.data_byte) begin
        res.result_code = CODE_CRC;
      end else begin
        res.result_code     = CODE_OK;
        res.humidity_raw    = fr_hum;
        res.temperature_raw = fr_temp;
      end
    end
    has = 1'b1;
    clear_frame();
  endtask

  task automatic send_byte(input in_item_t it, input bit use_typed = 1'b0,
                           input out_item_t typed = '0);
    bit        has;
    out_item_t res;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    decode_byte(it, has, res);
    if (has) pending_readings.push_back(use_typed ? typed : res);
    bytes_sent++;
    if (!tx_free && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    int unsigned pick;
    int unsigned n;
    int unsigned cut;
    in_item_t    it;
    pick = $urandom_range(99);
    if (pick < 15) begin
      n = $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
        it.data_byte = 8'($urandom);
        it.frame_end = (i == n - 1) || ($urandom_range(4) == 0);
        send_byte(it);
      end
    end else begin
      cut = (pick < 30) ? $urandom_range(0, 5) : 6;
      for (int i = 0; i <= cut; i++) begin
        if (fr_pos == CRC_BYTES) begin
          it.data_byte = fr_crc;
          if (pick < 42) it.data_byte = it.data_byte ^ (8'h01 << $urandom_range(7));
        end else begin
          it.data_byte = 8'($urandom);
          if (fr_pos == 3'd0 && $urandom_range(3) != 0)
            it.data_byte = it.data_byte & ~cfg_shadow.busy_mask;
        end
        if (i < cut)
          it.frame_end = 1'b0;
        else
          it.frame_end = (i < 6) ? 1'b1 : 1'($urandom_range(1));
        send_byte(it);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CRC_INITIAL:    cfg_shadow.crc_initial = val;
      CFG_CRC_POLYNOMIAL: cfg_shadow.crc_polynomial = val;
      CFG_BUSY_MASK:      cfg_shadow.busy_mask = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] init, input logic [7:0] poly,
                              input logic [7:0] mask, input bit poke_unused);
    write_reg(CFG_CRC_INITIAL, init);
    write_reg(CFG_CRC_POLYNOMIAL, poly);
    if (poke_unused) write_reg(CFG_UNUSED_INDEX, 8'($urandom));
    write_reg(CFG_BUSY_MASK, mask);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver side
  initial begin : rx_driver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_free) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 37);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: status %02h code %0d", out_item.status_byte,
               out_item.result_code);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        code_seen[out_item.result_code]++;
        if (out_item.humidity_raw !== want.humidity_raw) begin
          $error("humidity_raw: expected %05h, got %05h", want.humidity_raw,
                 out_item.humidity_raw);
          fail_count++;
        end
        if (out_item.temperature_raw !== want.temperature_raw) begin
          $error("temperature_raw: expected %05h, got %05h", want.temperature_raw,
                 out_item.temperature_raw);
          fail_count++;
        end
        if (out_item.status_byte !== want.status_byte) begin
          $error("status_byte: expected %02h, got %02h", want.status_byte,
                 out_item.status_byte);
          fail_count++;
        end
        if (out_item.result_code !== want.result_code) begin
          $error("result_code: expected %0d, got %0d", want.result_code,
                 out_item.result_code);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_item_t    it;
    int unsigned phase_start;
    int unsigned n;
    cfg_shadow.crc_initial    = CRC_INITIAL_RESET;
    cfg_shadow.crc_polynomial = CRC_POLYNOMIAL_RESET;
    cfg_shadow.busy_mask      = BUSY_MASK_RESET;
    clear_frame();
    bytes_sent    = 0;
    settings_used = 1;
    tx_free       = 1'b0;
    rx_free       = 1'b0;
    rx_hold_req   = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.frame_end = dir_rows[i].last;
      case (dir_rows[i].kind)
        ROW_CRC_GOOD: it.data_byte = fr_crc;
        ROW_CRC_BAD:  it.data_byte = ~fr_crc;
        default:      it.data_byte = dir_rows[i].data;
      endcase
      send_byte(it, dir_rows[i].kind inside {ROW_TYPED, ROW_CRC_BAD}, dir_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: program_regs(8'h00, 8'h00, 8'h00, 1'b0);
        1: program_regs(8'hFF, 8'hFF, 8'hFF, 1'b0);
        2: program_regs(CRC_INITIAL_RESET, CRC_POLYNOMIAL_RESET, BUSY_MASK_RESET, 1'b1);
        default: program_regs(8'($urandom), 8'($urandom), 8'h01 << $urandom_range(7),
                              ph == 4);
      endcase
      tx_free = (ph == 1) || (ph == 2);
      rx_free = (ph == 1);
      if (ph == 2) rx_hold_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_frame();
      // leave a frame open across the next register update
      if (ph % 2 == 1) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          it.data_byte = 8'($urandom);
          it.frame_end = 1'b0;
          send_byte(it);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes under %0d register settings, incl. long output hold-off.",
             bytes_sent, settings_used);
    $display("Results ok/busy/crc/short: %0d/%0d/%0d/%0d, field mismatches: %0d",
             code_seen[CODE_OK], code_seen[CODE_BUSY], code_seen[CODE_CRC],
             code_seen[CODE_SHORT], fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sfcd_pkg.sv
hw/rtl/sfcd_cfg.sv
hw/rtl/sfcd_core.sv
hw/rtl/sensor_frame_crc_decoder_top.sv
hw/rtl/sfcd_chk.sv
test/tb_sensor_frame_crc_decoder_top.sv
